// ===== rtl/core/rectangle_line_clipper_assert.svh =====
// ----------------------------------------------------------------------------
// rectangle_line_clipper_assert.svh
// Assertion macros used by the clipper RTL.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_LINE_CLIPPER_ASSERT_SVH
`define RECTANGLE_LINE_CLIPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rectangle_line_clipper: implication check failed");

// Implication delayed by the dly argument, disabled during reset.
`define RLC_ASSERT_DLY(lbl, ck, rn, ante, dly, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##(dly) (cons)) \
    else $error("rectangle_line_clipper: latency check failed");

`endif

// ===== rtl/core/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the rectangle line clipper.
// ----------------------------------------------------------------------------
package rlc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } cfg_reg_t;

  // Window edges, in the order in which they are applied.
  localparam int NUM_EDGES   = 4;
  localparam int EDGE_RIGHT  = 0;
  localparam int EDGE_LEFT   = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_BOTTOM = 3;

  // Classification of one edge constraint t*p <= q.
  typedef struct packed {
    logic par;    // p is zero: segment parallel to the edge
    logic qneg;   // q is negative
    logic neg;    // crossing parameter is negative
    logic big;    // crossing parameter magnitude exceeds one
    logic enter;  // p is negative: entering crossing
  } edge_flags_t;

endpackage

// ===== rtl/core/rectangle_line_clipper.sv =====
// ----------------------------------------------------------------------------
// rectangle_line_clipper
// Cyrus-Beck clipping of line segments against a rectangular window.
// ----------------------------------------------------------------------------
// A segment is transferred at a rising edge with start high and busy low;
// busy is high only while reset is applied and in the cycle that follows it.
// The result appears on the out_ ports for one cycle, marked by out_valid.
// The receiver cannot hold results off, and none is needed: the pipeline
// never stalls. One segment may be transferred in every cycle while busy
// is low, so throughput is one segment per cycle. The result passes
// through the delta and classification stages, the four parallel pipelined
// dividers, which produce one quotient bit per stage (FRAC_BITS + 1 stages),
// and the resolve, multiply and truncation stages.
// The window is held in four registers written through the cfg_ port
// (index 0 left, 1 right, 2 bottom, 3 top); cfg_ready is always high.
// Windows are to be written while no segment is in flight.
// Reset clears all valid bits and loads the window (-100,-100)-(100,100).
// A rejected segment returns its own endpoints with out_accepted low.
// ----------------------------------------------------------------------------
`include "rectangle_line_clipper_assert.svh"

module rectangle_line_clipper
  import rlc_pkg::*;
#(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Segment input
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  // Result output
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic signed [COORD_BITS-1:0] out_entry_x,
  output logic signed [COORD_BITS-1:0] out_entry_y,
  output logic signed [COORD_BITS-1:0] out_exit_x,
  output logic signed [COORD_BITS-1:0] out_exit_y,
  // Configuration write port
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic signed [COORD_BITS-1:0] cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = FB + CB + 3;
  localparam int LAT = FB + 6;
  localparam logic [FB:0] T_ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [PW-1:0] BIAS = {{(PW-FB){1'b0}}, {FB{1'b1}}};
  localparam logic signed [CB-1:0] WIN_LO = CB'(-100);
  localparam logic signed [CB-1:0] WIN_HI = CB'(100);

  // --------------------------------------------------------------------------
  // Window registers and handshake.
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] win_left_r, win_right_r, win_bottom_r, win_top_r;
  logic                 busy_r;
  logic                 in_xfer;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign in_xfer   = start && !busy_r;

  // Busy covers reset and the cycle that follows it.
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // A configuration transfer writes one window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= WIN_LO;
      win_right_r  <= WIN_HI;
      win_bottom_r <= WIN_LO;
      win_top_r    <= WIN_HI;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        default:    win_left_r   <= win_left_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: deltas and edge distances.
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [CB-1:0] x0_1_r, y0_1_r, x1_1_r, y1_1_r;
  logic signed [CB:0]   dx_1_r, dy_1_r;
  logic signed [CB:0]   q_1_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_xfer;
  end

  always_ff @(posedge clk) begin
    x0_1_r <= in_start_x;
    y0_1_r <= in_start_y;
    x1_1_r <= in_end_x;
    y1_1_r <= in_end_y;
    dx_1_r <= (CB+1)'(in_end_x) - (CB+1)'(in_start_x);
    dy_1_r <= (CB+1)'(in_end_y) - (CB+1)'(in_start_y);
    q_1_r[EDGE_RIGHT]  <= (CB+1)'(win_right_r)  - (CB+1)'(in_start_x);
    q_1_r[EDGE_LEFT]   <= (CB+1)'(in_start_x)   - (CB+1)'(win_left_r);
    q_1_r[EDGE_TOP]    <= (CB+1)'(win_top_r)    - (CB+1)'(in_start_y);
    q_1_r[EDGE_BOTTOM] <= (CB+1)'(in_start_y)   - (CB+1)'(win_bottom_r);
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes and classification of each edge.
  // --------------------------------------------------------------------------
  logic signed [CB:0]   p_s [NUM_EDGES];
  logic [CB-1:0]        pmag [NUM_EDGES];
  logic [CB-1:0]        qmag [NUM_EDGES];
  edge_flags_t [NUM_EDGES-1:0] fl_nxt;

  logic                 v2_r;
  logic signed [CB-1:0] x0_2_r, y0_2_r, x1_2_r, y1_2_r;
  logic signed [CB:0]   dx_2_r, dy_2_r;
  logic [CB-1:0]        num_2_r [NUM_EDGES];
  logic [CB-1:0]        den_2_r [NUM_EDGES];
  edge_flags_t [NUM_EDGES-1:0] fl_2_r;

  assign p_s[EDGE_RIGHT]  = dx_1_r;
  assign p_s[EDGE_LEFT]   = -dx_1_r;
  assign p_s[EDGE_TOP]    = dy_1_r;
  assign p_s[EDGE_BOTTOM] = -dy_1_r;

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      pmag[e] = p_s[e][CB] ? CB'(-p_s[e]) : CB'(p_s[e]);
      qmag[e] = q_1_r[e][CB] ? CB'(-q_1_r[e]) : CB'(q_1_r[e]);
      fl_nxt[e].par   = (p_s[e] == '0);
      fl_nxt[e].qneg  = q_1_r[e][CB];
      fl_nxt[e].neg   = (q_1_r[e] != '0) && (q_1_r[e][CB] != p_s[e][CB]);
      fl_nxt[e].big   = (qmag[e] > pmag[e]);
      fl_nxt[e].enter = p_s[e][CB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    x0_2_r  <= x0_1_r;
    y0_2_r  <= y0_1_r;
    x1_2_r  <= x1_1_r;
    y1_2_r  <= y1_1_r;
    dx_2_r  <= dx_1_r;
    dy_2_r  <= dy_1_r;
    fl_2_r  <= fl_nxt;
    num_2_r <= qmag;
    den_2_r <= pmag;
  end

  // --------------------------------------------------------------------------
  // Divider lanes, one per edge, with the segment carried alongside.
  // --------------------------------------------------------------------------
  logic [FB:0] quo [NUM_EDGES];

  genvar ge;
  generate
    for (ge = 0; ge < NUM_EDGES; ge++) begin : g_lane
      rlc_div #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
      ) u_div (
        .clk (clk),
        .num (num_2_r[ge]),
        .den (den_2_r[ge]),
        .quo (quo[ge])
      );
    end
  endgenerate

  logic                        vd_r  [FB+1];
  logic signed [CB-1:0]        x0_d_r [FB+1];
  logic signed [CB-1:0]        y0_d_r [FB+1];
  logic signed [CB-1:0]        x1_d_r [FB+1];
  logic signed [CB-1:0]        y1_d_r [FB+1];
  logic signed [CB:0]          dx_d_r [FB+1];
  logic signed [CB:0]          dy_d_r [FB+1];
  edge_flags_t [NUM_EDGES-1:0] fl_d_r [FB+1];

  // Valid bits follow the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= FB; k++) vd_r[k] <= 1'b0;
    end else begin
      vd_r[0] <= v2_r;
      for (int k = 1; k <= FB; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    x0_d_r[0] <= x0_2_r;
    y0_d_r[0] <= y0_2_r;
    x1_d_r[0] <= x1_2_r;
    y1_d_r[0] <= y1_2_r;
    dx_d_r[0] <= dx_2_r;
    dy_d_r[0] <= dy_2_r;
    fl_d_r[0] <= fl_2_r;
    for (int k = 1; k <= FB; k++) begin
      x0_d_r[k] <= x0_d_r[k-1];
      y0_d_r[k] <= y0_d_r[k-1];
      x1_d_r[k] <= x1_d_r[k-1];
      y1_d_r[k] <= y1_d_r[k-1];
      dx_d_r[k] <= dx_d_r[k-1];
      dy_d_r[k] <= dy_d_r[k-1];
      fl_d_r[k] <= fl_d_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: fold the crossings into the entering and leaving parameters.
  // --------------------------------------------------------------------------
  logic        rej_c;
  logic [FB:0] te_c, tl_c;
  edge_flags_t f_c;

  always_comb begin
    rej_c = 1'b0;
    te_c  = '0;
    tl_c  = T_ONE;
    f_c   = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      f_c = fl_d_r[FB][e];
      if (f_c.par) begin
        // Parallel edge: outside rejects, inside is ignored.
        if (f_c.qneg) rej_c = 1'b1;
      end else if (f_c.enter) begin
        // A negative entering crossing never raises t_enter.
        if (!f_c.neg) begin
          if (f_c.big)             rej_c = 1'b1;
          else if (quo[e] > te_c)  te_c  = quo[e];
        end
      end else begin
        // A leaving crossing below zero rejects, unless its quotient truncates to zero, which clamps.
        if (f_c.neg) begin
          if (f_c.big || (quo[e] != '0)) rej_c = 1'b1;
          else                           tl_c  = '0;
        end else if (!f_c.big && (quo[e] < tl_c)) begin
          tl_c = quo[e];
        end
      end
    end
  end

  logic                 v3_r, acc3_r;
  logic [FB:0]          te3_r, tl3_r;
  logic signed [CB-1:0] x0_3_r, y0_3_r, x1_3_r, y1_3_r;
  logic signed [CB:0]   dx_3_r, dy_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= vd_r[FB];
  end

  always_ff @(posedge clk) begin
    acc3_r <= !rej_c && (te_c <= tl_c);
    te3_r  <= te_c;
    tl3_r  <= tl_c;
    x0_3_r <= x0_d_r[FB];
    y0_3_r <= y0_d_r[FB];
    x1_3_r <= x1_d_r[FB];
    y1_3_r <= y1_d_r[FB];
    dx_3_r <= dx_d_r[FB];
    dy_3_r <= dy_d_r[FB];
  end

  // --------------------------------------------------------------------------
  // Stage 4: t times delta for both points.
  // --------------------------------------------------------------------------
  logic signed [FB+1:0] te_s, tl_s;
  logic                 v4_r, acc4_r;
  logic signed [PW-1:0] pex_4_r, pey_4_r, pxx_4_r, pxy_4_r;
  logic signed [CB-1:0] x0_4_r, y0_4_r, x1_4_r, y1_4_r;

  assign te_s = $signed({1'b0, te3_r});
  assign tl_s = $signed({1'b0, tl3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    acc4_r  <= acc3_r;
    pex_4_r <= PW'(te_s) * PW'(dx_3_r);
    pey_4_r <= PW'(te_s) * PW'(dy_3_r);
    pxx_4_r <= PW'(tl_s) * PW'(dx_3_r);
    pxy_4_r <= PW'(tl_s) * PW'(dy_3_r);
    x0_4_r  <= x0_3_r;
    y0_4_r  <= y0_3_r;
    x1_4_r  <= x1_3_r;
    y1_4_r  <= y1_3_r;
  end

  // --------------------------------------------------------------------------
  // Stage 5: add the start point and truncate toward zero.
  // --------------------------------------------------------------------------
  function automatic logic signed [CB-1:0] to_coord(
    input logic signed [CB-1:0] base,
    input logic signed [PW-1:0] prod
  );
    logic signed [PW-1:0] s;
    logic signed [PW-1:0] sb;
    s  = (PW'(base) <<< FB) + prod;
    sb = s[PW-1] ? (s + BIAS) : s;
    return CB'(sb >>> FB);
  endfunction

  logic                 out_valid_r, out_acc_r;
  logic signed [CB-1:0] ent_x_r, ent_y_r, ext_x_r, ext_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    out_acc_r <= acc4_r;
    ent_x_r   <= acc4_r ? to_coord(x0_4_r, pex_4_r) : x0_4_r;
    ent_y_r   <= acc4_r ? to_coord(y0_4_r, pey_4_r) : y0_4_r;
    ext_x_r   <= acc4_r ? to_coord(x0_4_r, pxx_4_r) : x1_4_r;
    ext_y_r   <= acc4_r ? to_coord(y0_4_r, pxy_4_r) : y1_4_r;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_entry_x  = ent_x_r;
  assign out_entry_y  = ent_y_r;
  assign out_exit_x   = ext_x_r;
  assign out_exit_y   = ext_y_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `RLC_ASSERT_DLY(a_latency, clk, rst_n, in_xfer, LAT, out_valid)
  `RLC_ASSERT_IMP(a_accept_order, clk, rst_n, v3_r && acc3_r, te3_r <= tl3_r)
  `RLC_ASSERT_IMP(a_leave_range, clk, rst_n, v3_r, tl3_r <= T_ONE)

endmodule

// ===== rtl/core/rlc_div.sv =====
// ----------------------------------------------------------------------------
// rlc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
module rlc_div #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] num,
  input  logic [COORD_BITS-1:0] den,
  output logic [FRAC_BITS:0]    quo
);

  logic [COORD_BITS-1:0] rem_r [FRAC_BITS];
  logic [COORD_BITS-1:0] den_r [FRAC_BITS];
  logic [FRAC_BITS:0]    quo_r [FRAC_BITS+1];

  genvar j;
  generate
    for (j = 0; j <= FRAC_BITS; j++) begin : g_stage
      logic [COORD_BITS:0]   r_in;
      logic [COORD_BITS-1:0] d_in;
      logic [FRAC_BITS:0]    q_in;
      logic [COORD_BITS:0]   diff;
      logic                  ge;

      // Select the partial remainder entering this stage.
      if (j == 0) begin : g_first
        assign r_in = {1'b0, num};
        assign d_in = den;
        assign q_in = '0;
      end else begin : g_next
        assign r_in = {rem_r[j-1], 1'b0};
        assign d_in = den_r[j-1];
        assign q_in = quo_r[j-1];
      end

      // Trial subtraction decides one quotient bit.
      assign diff = r_in - {1'b0, d_in};
      assign ge   = (r_in >= {1'b0, d_in});

      always_ff @(posedge clk) begin
        quo_r[j] <= {q_in[FRAC_BITS-1:0], ge};
      end

      if (j < FRAC_BITS) begin : g_rem
        always_ff @(posedge clk) begin
          rem_r[j] <= ge ? diff[COORD_BITS-1:0] : r_in[COORD_BITS-1:0];
          den_r[j] <= d_in;
        end
      end
    end
  endgenerate

  assign quo = quo_r[FRAC_BITS];

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Rectangle line clipper testbench
// Sends segments to the clipper against a series of window settings and
// checks every result against a behavioural Cyrus-Beck clipping predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rlc_pkg::*;

  localparam int CB       = 13;
  localparam int FB       = 16;
  localparam int LATENCY  = FB + 6;
  localparam int SETTLE   = LATENCY + 4;
  localparam int WATCHDOG = 4000;
  localparam longint T_ONE = longint'(1) << FB;

  typedef logic signed [CB-1:0] coord_t;

  typedef enum logic [1:0] {ACT_SEGMENT, ACT_WRITE, ACT_DRAIN} action_t;

  typedef struct {
    action_t  kind;
    cfg_reg_t reg_idx;
    coord_t   wr_data;
    coord_t   sx, sy, ex, ey;
    int       gap;
  } stim_t;

  typedef struct packed {
    logic   acc;
    coord_t entry_x, entry_y, exit_x, exit_y;
  } clip_t;

  logic   clk, rst_n;
  logic   start, busy;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y;
  logic   out_valid, out_accepted;
  coord_t out_entry_x, out_entry_y, out_exit_x, out_exit_y;
  logic   cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  coord_t cfg_data;

  stim_t  stim_q[$];
  clip_t  clip_q[$];
  coord_t win_left, win_right, win_bottom, win_top;
  int     quiet, gap_cnt, stall, n_err, n_seg, n_acc, n_rej, n_wr;
  bit     burst;

  wire seg_xfer = start && !busy;
  wire cfg_xfer = cfg_valid && cfg_ready;

  rectangle_line_clipper #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .out_valid, .out_accepted, .out_entry_x, .out_entry_y, .out_exit_x, .out_exit_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Point on the segment at parameter t, truncated toward zero.
  function automatic coord_t point_at(longint s, longint d, longint t);
    return coord_t'((s * T_ONE + t * d) / T_ONE);
  endfunction

  // Cyrus-Beck clipping of one segment against the current window.
  function automatic clip_t clip_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    longint dx, dy, t_in, t_out, t;
    longint p[4], q[4];
    bit     rej;
    clip_t  r;
    dx = longint'(x1) - longint'(x0);
    dy = longint'(y1) - longint'(y0);
    t_in = 0;
    t_out = T_ONE;
    rej = 1'b0;
    p[0] = dx;  q[0] = longint'(win_right) - x0;
    p[1] = -dx; q[1] = longint'(x0) - win_left;
    p[2] = dy;  q[2] = longint'(win_top) - y0;
    p[3] = -dy; q[3] = longint'(y0) - win_bottom;
    for (int i = 0; i < 4; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) rej = 1'b1;
      end else begin
        t = (q[i] * T_ONE) / p[i];
        if (p[i] > 0 && t < t_out) t_out = t;
        if (p[i] < 0 && t > t_in) t_in = t;
      end
    end
    if (!rej && t_in <= t_out) begin
      r.acc = 1'b1;
      r.entry_x = point_at(x0, dx, t_in);
      r.entry_y = point_at(y0, dy, t_in);
      r.exit_x = point_at(x0, dx, t_out);
      r.exit_y = point_at(y0, dy, t_out);
    end else begin
      r = '{1'b0, x0, y0, x1, y1};
    end
    return r;
  endfunction

  // Driver: applies pending actions; window writes and drains wait for an idle pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_index <= REG_LEFT;
      cfg_data <= '0;
      in_start_x <= '0; in_start_y <= '0; in_end_x <= '0; in_end_y <= '0;
      gap_cnt <= 0;
      quiet <= 0;
      win_left <= coord_t'(-100); win_right <= coord_t'(100);
      win_bottom <= coord_t'(-100); win_top <= coord_t'(100);
    end else begin
      quiet <= (seg_xfer || out_valid) ? 0 : quiet + 1;
      if (seg_xfer) begin
        clip_q.push_back(clip_segment(in_start_x, in_start_y, in_end_x, in_end_y));
        n_seg++;
      end
      if (cfg_xfer) begin
        case (cfg_reg_t'(cfg_index))
          REG_LEFT:   win_left <= cfg_data;
          REG_RIGHT:  win_right <= cfg_data;
          REG_BOTTOM: win_bottom <= cfg_data;
          REG_TOP:    win_top <= cfg_data;
        endcase
        n_wr++;
      end
      if ((start && busy) || (cfg_valid && !cfg_ready)) begin
        // Hold the offered transfer.
      end else if (gap_cnt > 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (stim_q.size() > 0 && stim_q[0].kind == ACT_SEGMENT) begin
        start <= 1'b1;
        cfg_valid <= 1'b0;
        in_start_x <= stim_q[0].sx; in_start_y <= stim_q[0].sy;
        in_end_x <= stim_q[0].ex;   in_end_y <= stim_q[0].ey;
        gap_cnt <= stim_q[0].gap;
        void'(stim_q.pop_front());
      end else if (stim_q.size() > 0 && clip_q.size() == 0 && quiet >= SETTLE
                   && !seg_xfer && !cfg_xfer) begin
        start <= 1'b0;
        cfg_valid <= stim_q[0].kind == ACT_WRITE;
        cfg_index <= stim_q[0].reg_idx;
        cfg_data <= stim_q[0].wr_data;
        void'(stim_q.pop_front());
      end else begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    clip_t exp_r;
    if (rst_n && out_valid) begin
      if (clip_q.size() == 0) begin
        $display("%0t: unexpected result acc=%0d entry=(%0d,%0d) exit=(%0d,%0d)", $time,
                 out_accepted, out_entry_x, out_entry_y, out_exit_x, out_exit_y);
        n_err++;
      end else begin
        exp_r = clip_q.pop_front();
        if (exp_r.acc) n_acc++; else n_rej++;
        if (exp_r !== {out_accepted, out_entry_x, out_entry_y, out_exit_x, out_exit_y}) begin
          $display({"%0t: mismatch expected acc=%0d entry=(%0d,%0d) exit=(%0d,%0d)",
                    " actual acc=%0d entry=(%0d,%0d) exit=(%0d,%0d)"},
                   $time, exp_r.acc, exp_r.entry_x, exp_r.entry_y, exp_r.exit_x,
                   exp_r.exit_y, out_accepted, out_entry_x, out_entry_y, out_exit_x,
                   out_exit_y);
          n_err++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer or result.
  always @(posedge clk) begin
    if (!rst_n || seg_xfer || cfg_xfer || out_valid) begin
      stall <= 0;
    end else if (stall >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  task automatic add_seg(int x0, int y0, int x1, int y1);
    stim_t s;
    s.kind = ACT_SEGMENT;
    s.sx = coord_t'(x0); s.sy = coord_t'(y0); s.ex = coord_t'(x1); s.ey = coord_t'(y1);
    s.gap = burst ? 0 : $urandom_range(0, 12);
    stim_q.push_back(s);
  endtask

  task automatic add_window(int l, int r, int b, int t);
    stim_t s;
    int v[4];
    v = '{l, r, b, t};
    s.kind = ACT_WRITE;
    s.gap = 0;
    for (int i = 0; i < 4; i++) begin
      s.reg_idx = cfg_reg_t'(i);
      s.wr_data = coord_t'(v[i]);
      stim_q.push_back(s);
    end
  endtask

  task automatic add_drain();
    stim_t s;
    s.kind = ACT_DRAIN;
    s.gap = 0;
    stim_q.push_back(s);
  endtask

  // Coordinate near the window span, kept within the field range.
  function automatic int near(int lo, int hi);
    int a, b, v;
    a = (lo < hi ? lo : hi) - 150;
    b = (lo < hi ? hi : lo) + 150;
    v = a + int'($urandom_range(0, b - a));
    return v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // Stimulus and end of run.
  initial begin
    int l, r, b, t, x0, y0, x1, y1;
    n_err = 0; n_seg = 0; n_acc = 0; n_rej = 0; n_wr = 0;
    burst = 1'b0;
    // Directed: reset window, parallel edges, degenerate points, field extremes.
    add_seg(-50, -50, 50, 50);
    add_seg(-200, 0, 200, 0);
    add_seg(0, -200, 0, 200);
    add_seg(-200, 150, 200, 150);
    add_seg(150, -200, 150, 200);
    add_seg(10, 10, 10, 10);
    add_seg(300, 300, 300, 300);
    add_seg(-4096, -4096, 4095, 4095);
    add_seg(4095, -4096, -4096, 4095);
    add_seg(-4096, -4096, -4096, -4096);
    add_seg(4095, 4095, 4095, 4095);
    add_seg(-4096, 4095, 4095, -4096);
    add_seg(100, 100, 100, 100);
    add_seg(-100, -100, 300, -100);
    add_seg(-300, 0, -150, 0);
    add_seg(0, 0, 500, 37);
    add_seg(-150, 250, 250, -150);
    add_window(-4096, 4095, -4096, 4095);
    add_seg(-4096, -4096, 4095, 4095);
    add_seg(4095, 0, -4096, 1);
    add_window(50, -50, 50, -50);
    add_seg(-100, 0, 100, 0);
    add_seg(0, 0, 0, 0);
    add_window(0, 0, 0, 0);
    add_seg(0, 0, 0, 0);
    add_seg(-5, -5, 5, 5);
    add_window(4095, -4096, 4095, -4096);
    add_seg(0, 0, 1, 1);
    // Random phases, each with its own window.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin l = -4096; r = 4095; b = -4096; t = 4095; end
        1: begin l = -100; r = 100; b = -100; t = 100; end
        2: begin l = 200; r = -200; b = -50; t = 50; end
        3: begin l = 7; r = 7; b = -3; t = 40; end
        default: begin
          l = any_coord(); r = any_coord(); b = any_coord(); t = any_coord();
          if (l > r) begin x0 = l; l = r; r = x0; end
          if (b > t) begin x0 = b; b = t; t = x0; end
        end
      endcase
      add_window(l, r, b, t);
      for (int n = 0; n < 90; n++) begin
        if (n % 30 == 0) burst = $urandom_range(0, 2) == 0;
        if (n == 45) add_drain();
        case ($urandom_range(0, 9))
          0, 1: begin x0 = any_coord(); y0 = any_coord(); x1 = any_coord(); y1 = any_coord(); end
          2: begin x0 = near(l, r); x1 = near(l, r); y0 = near(b, t); y1 = y0; end
          3: begin y0 = near(b, t); y1 = near(b, t); x0 = near(l, r); x1 = x0; end
          4: begin x0 = near(l, r); y0 = near(b, t); x1 = x0; y1 = y0; end
          default: begin x0 = near(l, r); y0 = near(b, t); x1 = near(l, r); y1 = near(b, t); end
        endcase
        add_seg(x0, y0, x1, y1);
      end
    end
    // Wait for the queue to empty and every expected result to arrive.
    wait (rst_n);
    while (stim_q.size() > 0 || start || cfg_valid || clip_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Clipped %0d segments (%0d accepted, %0d rejected) over %0d window writes.",
             n_seg, n_acc, n_rej, n_wr);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
